/* hdl/assert_macros.svh */
// Assertion macros for the fixed-point ALU, included by fixed_point_alu_unit.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define FPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* hdl/fpa_pkg.sv */
// Package of the fixed-point ALU: opcodes, status codes and the sideband word.
// Used by fpa_front, fpa_div_cell and fixed_point_alu_unit.
`default_nettype none

package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [3:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_GT       = 4'd4,
        FN_LT       = 4'd5,
        FN_GE       = 4'd6,
        FN_LE       = 4'd7,
        FN_EQ       = 4'd8,
        FN_NE       = 4'd9,
        FN_MIN      = 4'd10,
        FN_MAX      = 4'd11,
        FN_INC      = 4'd12,
        FN_FROM_INT = 4'd13,
        FN_TO_INT   = 4'd14
    } fpa_func_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Sideband that rides along the divider chain with every word.
    typedef struct packed {
        logic [3:0]        func;
        logic signed [31:0] res;
        logic              cmp;
        logic [1:0]        st;
        logic              neg;
        logic              is_div;
    } fpa_side_t;

endpackage

`default_nettype wire

/* hdl/fpa_front.sv */
// Front pipeline of the fixed-point ALU: simple ops, multiplier, divide setup.
// Depends on fpa_pkg.
`default_nettype none

module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int NB        = 33 + FRAC_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [3:0]              in_func,
    input  wire logic signed [31:0]      in_a,
    input  wire logic signed [31:0]      in_b,
    output logic                         out_valid,
    output fpa_pkg::fpa_side_t           out_side,
    output logic [31:0]                  out_divisor,
    output logic [NB-1:0]                out_dividend
);
    import fpa_pkg::*;

    localparam int FW = 32 + FRAC_BITS;
    localparam logic [FW-1:0] FI_POS_LIM = FW'(32'h7FFF_FFFF);
    localparam logic [FW-1:0] FI_NEG_LIM = FW'(32'h8000_0000);
    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] MUL_POS_LIM = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] MUL_NEG_LIM = 64'h0000_0000_8000_0000;

    // Stage 1: input registers.
    logic [3:0]          valid_reg;
    logic [3:0]          func1_reg;
    logic signed [31:0]  a1_reg, b1_reg;

    // Stage 2: product, simple results, divide setup.
    logic signed [63:0]  prod2_reg, prod2_next;
    fpa_side_t           side2_reg, side2_next;
    logic [31:0]         div2_reg, div2_next;
    logic [NB-1:0]       dvd2_reg, dvd2_next;

    // Stage 3: product magnitude.
    logic [63:0]         mag3_reg, mag3_next;
    logic                pneg3_reg;
    fpa_side_t           side3_reg;
    logic [31:0]         div3_reg;
    logic [NB-1:0]       dvd3_reg;

    // Stage 4: rounded and saturated product.
    fpa_side_t           side4_reg, side4_next;
    logic [31:0]         div4_reg;
    logic [NB-1:0]       dvd4_reg;

    // Valid bits of stages 1 to 4.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // Operations that finish in one step, plus setup for multiply and divide.
    always_comb begin
        logic signed [32:0] sum;
        logic signed [32:0] dif;
        logic [31:0]        mag_a;
        logic [31:0]        mag_b;
        logic [FW-1:0]      fi;
        side2_next        = '0;
        side2_next.func   = func1_reg;
        side2_next.st     = ST_OK;
        sum   = {a1_reg[31], a1_reg} + {b1_reg[31], b1_reg};
        dif   = {a1_reg[31], a1_reg} - {b1_reg[31], b1_reg};
        mag_a = a1_reg[31] ? 32'(-a1_reg) : a1_reg;
        mag_b = b1_reg[31] ? 32'(-b1_reg) : b1_reg;
        fi    = {mag_a, {FRAC_BITS{1'b0}}};
        prod2_next = 64'(a1_reg) * 64'(b1_reg);
        div2_next  = mag_b;
        dvd2_next  = {mag_a, {(FRAC_BITS + 1){1'b0}}};
        case (func1_reg)
            FN_ADD: begin
                if (sum[32] != sum[31]) begin
                    side2_next.res = sum[32] ? SAT_MIN : SAT_MAX;
                    side2_next.st  = ST_OVF;
                end else begin
                    side2_next.res = sum[31:0];
                end
            end
            FN_SUB: begin
                if (dif[32] != dif[31]) begin
                    side2_next.res = dif[32] ? SAT_MIN : SAT_MAX;
                    side2_next.st  = ST_OVF;
                end else begin
                    side2_next.res = dif[31:0];
                end
            end
            FN_DIV: begin
                if (b1_reg == 32'sd0) begin
                    side2_next.res = a1_reg[31] ? SAT_MIN : SAT_MAX;
                    side2_next.st  = ST_DIV0;
                end else begin
                    side2_next.is_div = 1'b1;
                    side2_next.neg    = a1_reg[31] ^ b1_reg[31];
                end
            end
            FN_GT: side2_next.cmp = a1_reg > b1_reg;
            FN_LT: side2_next.cmp = a1_reg < b1_reg;
            FN_GE: side2_next.cmp = a1_reg >= b1_reg;
            FN_LE: side2_next.cmp = a1_reg <= b1_reg;
            FN_EQ: side2_next.cmp = a1_reg == b1_reg;
            FN_NE: side2_next.cmp = a1_reg != b1_reg;
            FN_MIN: side2_next.res = (a1_reg <= b1_reg) ? a1_reg : b1_reg;
            FN_MAX: side2_next.res = (a1_reg >= b1_reg) ? a1_reg : b1_reg;
            FN_INC: begin
                if (a1_reg == SAT_MAX) begin
                    side2_next.res = SAT_MAX;
                    side2_next.st  = ST_OVF;
                end else begin
                    side2_next.res = a1_reg + 32'sd1;
                end
            end
            FN_FROM_INT: begin
                if (a1_reg[31] && fi > FI_NEG_LIM) begin
                    side2_next.res = SAT_MIN;
                    side2_next.st  = ST_OVF;
                end else if (!a1_reg[31] && fi > FI_POS_LIM) begin
                    side2_next.res = SAT_MAX;
                    side2_next.st  = ST_OVF;
                end else begin
                    side2_next.res = a1_reg[31] ? 32'(-fi[31:0]) : fi[31:0];
                end
            end
            FN_TO_INT: side2_next.res = a1_reg >>> FRAC_BITS;
            default: side2_next.res = '0;
        endcase
    end

    // Product magnitude.
    assign mag3_next = prod2_reg[63] ? 64'(-prod2_reg) : prod2_reg;

    // Round half away from zero, then saturate the product.
    always_comb begin
        logic [63:0] rm;
        side4_next = side3_reg;
        rm = (mag3_reg + HALF) >> FRAC_BITS;
        if (side3_reg.func == FN_MUL) begin
            if (pneg3_reg && rm > MUL_NEG_LIM) begin
                side4_next.res = SAT_MIN;
                side4_next.st  = ST_OVF;
            end else if (!pneg3_reg && rm > MUL_POS_LIM) begin
                side4_next.res = SAT_MAX;
                side4_next.st  = ST_OVF;
            end else begin
                side4_next.res = pneg3_reg ? 32'(-rm[31:0]) : rm[31:0];
            end
        end
    end

    // Payload registers of all front stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            func1_reg <= in_func;
            a1_reg    <= in_a;
            b1_reg    <= in_b;
            prod2_reg <= prod2_next;
            side2_reg <= side2_next;
            div2_reg  <= div2_next;
            dvd2_reg  <= dvd2_next;
            mag3_reg  <= mag3_next;
            pneg3_reg <= prod2_reg[63];
            side3_reg <= side2_reg;
            div3_reg  <= div2_reg;
            dvd3_reg  <= dvd2_reg;
            side4_reg <= side4_next;
            div4_reg  <= div3_reg;
            dvd4_reg  <= dvd3_reg;
        end
    end

    assign out_valid    = valid_reg[3];
    assign out_side     = side4_reg;
    assign out_divisor  = div4_reg;
    assign out_dividend = dvd4_reg;

endmodule

`default_nettype wire

/* hdl/fpa_div_cell.sv */
// One cell of the divider chain: produces one quotient bit per word.
// Depends on fpa_pkg for the sideband word.
`default_nettype none

module fpa_div_cell #(
    parameter int NB = 33 + fpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  fpa_pkg::fpa_side_t      in_side,
    input  wire logic [31:0]        in_divisor,
    input  wire logic [31:0]        in_rem,
    input  wire logic [NB-1:0]      in_dq,
    output logic                    out_valid,
    output fpa_pkg::fpa_side_t      out_side,
    output logic [31:0]             out_divisor,
    output logic [31:0]             out_rem,
    output logic [NB-1:0]           out_dq
);
    import fpa_pkg::*;

    logic               valid_reg;
    fpa_side_t          side_reg;
    logic [31:0]        div_reg;
    logic [31:0]        rem_reg, rem_next;
    logic [NB-1:0]      dq_reg, dq_next;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        logic [32:0] trial;
        logic        qbit;
        trial = {in_rem, in_dq[NB-1]};
        qbit  = trial >= {1'b0, in_divisor};
        rem_next = qbit ? 32'(trial - {1'b0, in_divisor}) : trial[31:0];
        dq_next  = {in_dq[NB-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            div_reg  <= in_divisor;
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_side    = side_reg;
    assign out_divisor = div_reg;
    assign out_rem     = rem_reg;
    assign out_dq      = dq_reg;

endmodule

`default_nettype wire

/* hdl/fixed_point_alu_unit.sv */
// Top level of the signed fixed-point ALU (32-bit raw words, FRAC_BITS fraction bits).
// Depends on fpa_pkg, fpa_front, fpa_div_cell and assert_macros.svh.
//
// Usage: each input word carries an opcode and two raw operands; each one yields
// exactly one output word with the result, a compare flag and a status code.
// Input channel s_*: s_tdata = func[3:0], operand_a[35:4], operand_b[67:36].
// Output channel m_*: m_tdata = result[31:0], compare_true[32], status[34:33].
// Every word, whatever its opcode, walks the same pipeline: four front stages
// (input register, 32x32 multiplier, product magnitude, rounding), then a chain
// of 33 + FRAC_BITS divider cells that each settle one quotient bit, then the
// output register. Throughput is one word per cycle while the output is not
// stalled; results leave in input order.
// When the receiver holds m_tready low with a word waiting, the whole pipeline
// freezes and s_tready drops in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline; no word is in flight afterwards.
`default_nettype none

module fixed_point_alu_unit #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // func[3:0], operand_a[35:4], operand_b[67:36], zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // result[31:0], compare_true[32], status[34:33], zero
);
    import fpa_pkg::*;
    `include "assert_macros.svh"

    localparam int NB = 33 + FRAC_BITS;
    localparam logic [NB-1:0] DIV_POS_LIM = NB'(32'h7FFF_FFFF);
    localparam logic [NB-1:0] DIV_NEG_LIM = NB'(32'h8000_0000);

    logic en;

    // Chain taps: index 0 is the front output, index NB the last cell.
    logic          c_valid   [NB+1];
    fpa_side_t     c_side    [NB+1];
    logic [31:0]   c_divisor [NB+1];
    logic [31:0]   c_rem     [NB+1];
    logic [NB-1:0] c_dq      [NB+1];

    logic               m_tvalid_reg;
    logic signed [31:0] res_reg, res_next;
    logic               cmp_reg;
    logic [1:0]         st_reg, st_next;

    // The pipeline moves whenever the output register is free or being drained.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    fpa_front #(
        .FRAC_BITS (FRAC_BITS),
        .NB        (NB)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .in_func      (s_tdata[3:0]),
        .in_a         (s_tdata[35:4]),
        .in_b         (s_tdata[67:36]),
        .out_valid    (c_valid[0]),
        .out_side     (c_side[0]),
        .out_divisor  (c_divisor[0]),
        .out_dividend (c_dq[0])
    );
    assign c_rem[0] = '0;

    // Restoring divider, one cell per quotient bit.
    for (genvar i = 0; i < NB; i++) begin : g_cell
        fpa_div_cell #(
            .NB (NB)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (en),
            .in_valid    (c_valid[i]),
            .in_side     (c_side[i]),
            .in_divisor  (c_divisor[i]),
            .in_rem      (c_rem[i]),
            .in_dq       (c_dq[i]),
            .out_valid   (c_valid[i+1]),
            .out_side    (c_side[i+1]),
            .out_divisor (c_divisor[i+1]),
            .out_rem     (c_rem[i+1]),
            .out_dq      (c_dq[i+1])
        );
    end

    // The chain gives floor(2n/d); adding one and halving rounds half away from zero.
    always_comb begin
        logic [NB:0]   qp;
        logic [NB-1:0] q;
        qp       = {1'b0, c_dq[NB]} + (NB+1)'(1);
        q        = qp[NB:1];
        res_next = c_side[NB].res;
        st_next  = c_side[NB].st;
        if (c_side[NB].is_div) begin
            if (c_side[NB].neg && q > DIV_NEG_LIM) begin
                res_next = SAT_MIN;
                st_next  = ST_OVF;
            end else if (!c_side[NB].neg && q > DIV_POS_LIM) begin
                res_next = SAT_MAX;
                st_next  = ST_OVF;
            end else begin
                res_next = c_side[NB].neg ? 32'(-q[31:0]) : q[31:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= c_valid[NB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
            cmp_reg <= c_side[NB].cmp;
            st_reg  <= st_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, st_reg, cmp_reg, res_reg};

    // The remainder never reaches the divisor on a real divide.
    logic unused_rem;
    assign unused_rem = ^c_rem[NB];

    // The top bits of the input word are padding.
    logic unused_pad;
    assign unused_pad = ^s_tdata[71:68];

    `FPA_ASSERT(a_sat_bounds, m_tvalid && (st_reg == ST_OVF || st_reg == ST_DIV0) |-> res_reg == SAT_MAX || res_reg == SAT_MIN, "saturated result is not a bound")
    `FPA_ASSERT(a_cmp_clean, m_tvalid && cmp_reg |-> res_reg == 32'sd0 && st_reg == ST_OK, "compare word carries result or status")
    `FPA_ASSERT(a_div_rem, c_valid[NB] && c_side[NB].is_div |-> c_rem[NB] < c_divisor[NB], "divider remainder not below divisor")
    `FPA_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "output valid right after reset")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench of the fixed-point ALU: directed table, then random words.
// Depends on fpa_pkg and fixed_point_alu_unit.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import fpa_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int N_RANDOM = 1500;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic signed [31:0] result;
        logic               cmp;
        logic [1:0]         st;
    } alu_out_t;

    typedef struct {
        logic [3:0]         func;
        logic signed [31:0] a;
        logic signed [31:0] b;
        bit                 typed;
        alu_out_t           want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    alu_out_t    expected_q[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          quiet_phase = 0;
    bit          done_sending = 0;

    fixed_point_alu_unit #(.FRAC_BITS(FB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Clamp a wide value to 32 bits, flagging overflow.
    function automatic alu_out_t clamp_word(logic signed [71:0] v);
        alu_out_t o;
        o = '0;
        if (v > 72'sd2147483647) begin
            o.result = SAT_MAX;
            o.st = ST_OVF;
        end else if (v < -72'sd2147483648) begin
            o.result = SAT_MIN;
            o.st = ST_OVF;
        end else begin
            o.result = v[31:0];
        end
        return o;
    endfunction

    // Exact fixed-point arithmetic for one operation word.
    function automatic alu_out_t alu_predict(logic [3:0] func, logic signed [31:0] a,
                                             logic signed [31:0] b);
        alu_out_t o;
        logic signed [71:0] wa, wb, p;
        logic [71:0] mag, n, d, q;
        bit neg;
        o = '0;
        wa = 72'(a);
        wb = 72'(b);
        case (func)
            FN_ADD: o = clamp_word(wa + wb);
            FN_SUB: o = clamp_word(wa - wb);
            FN_MUL: begin
                p = wa * wb;
                mag = (p < 0) ? -p : p;
                mag = (mag + (72'd1 << (FB - 1))) >> FB;
                o = clamp_word((p < 0) ? -$signed(mag) : $signed(mag));
            end
            FN_DIV: begin
                if (b == 0) begin
                    o.result = (a >= 0) ? SAT_MAX : SAT_MIN;
                    o.st = ST_DIV0;
                end else begin
                    n = ((wa < 0) ? -wa : wa) << FB;
                    d = (wb < 0) ? -wb : wb;
                    q = (72'd2 * n + d) / (72'd2 * d);
                    neg = (a < 0) != (b < 0);
                    o = clamp_word(neg ? -$signed(q) : $signed(q));
                end
            end
            FN_GT: o.cmp = a > b;
            FN_LT: o.cmp = a < b;
            FN_GE: o.cmp = a >= b;
            FN_LE: o.cmp = a <= b;
            FN_EQ: o.cmp = a == b;
            FN_NE: o.cmp = a != b;
            FN_MIN: o.result = (a <= b) ? a : b;
            FN_MAX: o.result = (a >= b) ? a : b;
            FN_INC: o = clamp_word(wa + 72'sd1);
            FN_FROM_INT: o = clamp_word(wa <<< FB);
            FN_TO_INT: o.result = a >>> FB;
            default: o = '0;
        endcase
        return o;
    endfunction

    // Random operand, biased toward the edges of the range and small values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return SAT_MAX - $urandom_range(0, 3);
            1: return SAT_MIN + $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;
            3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    // Drive one word at the falling edge and hold it until accepted.
    task automatic send_word(logic [3:0] func, logic [31:0] a, logic [31:0] b,
                             bit typed, alu_out_t want);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {4'b0, b, a, func};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(typed ? want : alu_predict(func, a, b));
        @(negedge aclk);
    endtask

    // Receiver: random stall bursts; compare each accepted word.
    initial begin
        alu_out_t got, want;
        int stall;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 8);
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[32], m_tdata[34:33]};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected output word %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: result %h/%h cmp %b/%b status %0d/%0d",
                                     want.result, got.result, want.cmp, got.cmp,
                                     want.st, got.st);
                    end
                end
            end
            @(negedge aclk);
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !done_sending) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus: directed table, random words, then drain.
    initial begin
        stim_row_t rows[$];
        stim_row_t r;
        logic [3:0] fn;
        int k, drain;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows; typed results where they are obvious.
        rows.push_back('{FN_ADD, SAT_MAX, 32'sd1, 1, '{SAT_MAX, 1'b0, ST_OVF}});
        rows.push_back('{FN_SUB, SAT_MIN, 32'sd1, 1, '{SAT_MIN, 1'b0, ST_OVF}});
        rows.push_back('{FN_MUL, SAT_MAX, SAT_MAX, 1, '{SAT_MAX, 1'b0, ST_OVF}});
        rows.push_back('{FN_MUL, SAT_MIN, SAT_MAX, 1, '{SAT_MIN, 1'b0, ST_OVF}});
        rows.push_back('{FN_MUL, 32'sd384, -32'sd1, 0, '0});
        rows.push_back('{FN_MUL, -32'sd128, 32'sd1, 0, '0});
        rows.push_back('{FN_DIV, 32'sd5, 32'sd0, 1, '{SAT_MAX, 1'b0, ST_DIV0}});
        rows.push_back('{FN_DIV, 32'sd0, 32'sd0, 1, '{SAT_MAX, 1'b0, ST_DIV0}});
        rows.push_back('{FN_DIV, -32'sd5, 32'sd0, 1, '{SAT_MIN, 1'b0, ST_DIV0}});
        rows.push_back('{FN_DIV, SAT_MIN, 32'sd1, 1, '{SAT_MIN, 1'b0, ST_OVF}});
        rows.push_back('{FN_DIV, -32'sd3, 32'sd2048, 0, '0});
        rows.push_back('{FN_GT, SAT_MAX, SAT_MIN, 1, '{32'sd0, 1'b1, ST_OK}});
        rows.push_back('{FN_LT, SAT_MAX, SAT_MIN, 1, '{32'sd0, 1'b0, ST_OK}});
        rows.push_back('{FN_GE, 32'sd7, 32'sd7, 1, '{32'sd0, 1'b1, ST_OK}});
        rows.push_back('{FN_LE, 32'sd7, 32'sd7, 1, '{32'sd0, 1'b1, ST_OK}});
        rows.push_back('{FN_EQ, SAT_MIN, SAT_MIN, 1, '{32'sd0, 1'b1, ST_OK}});
        rows.push_back('{FN_NE, SAT_MIN, SAT_MIN, 1, '{32'sd0, 1'b0, ST_OK}});
        rows.push_back('{FN_MIN, SAT_MIN, SAT_MAX, 1, '{SAT_MIN, 1'b0, ST_OK}});
        rows.push_back('{FN_MAX, SAT_MIN, SAT_MAX, 1, '{SAT_MAX, 1'b0, ST_OK}});
        rows.push_back('{FN_INC, SAT_MAX, 32'sd0, 1, '{SAT_MAX, 1'b0, ST_OVF}});
        rows.push_back('{FN_FROM_INT, SAT_MIN, 32'sd0, 1, '{SAT_MIN, 1'b0, ST_OVF}});
        rows.push_back('{FN_FROM_INT, -32'sd1, 32'sd0, 1, '{-32'sd256, 1'b0, ST_OK}});
        rows.push_back('{FN_TO_INT, -32'sd1, 32'sd0, 1, '{-32'sd1, 1'b0, ST_OK}});
        rows.push_back('{FN_TO_INT, SAT_MAX, SAT_MAX, 0, '0});
        rows.push_back('{4'd15, SAT_MAX, SAT_MIN, 1, '{32'sd0, 1'b0, ST_OK}});
        foreach (rows[i]) begin
            r = rows[i];
            send_word(r.func, r.a, r.b, r.typed, r.want);
        end

        // Random words; the last stretch runs without idling.
        for (k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM - 200) quiet_phase = 1;
            fn = 4'($urandom_range(0, 15));
            send_word(fn, pick_operand(), pick_operand(), 0, '0);
        end
        s_tvalid <= 1'b0;
        done_sending = 1;

        drain = 0;
        while (expected_q.size() != 0 && drain < 5000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire
